FILE: src/fipid_pkg.sv
// shared constants and types for the filtered incremental pid controller
package fipid_pkg;

    // field and state widths
    localparam int SAMPLE_W    = 12;
    localparam int ACC_W       = 32;
    localparam int FRAC_BITS   = 20;
    localparam int LEVEL_W     = 9;
    localparam int ERR_W       = 10;
    localparam int DUTY_W      = 8;
    localparam int GAIN_W      = 32;
    localparam int GAIN_FRAC   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // level scaling: (whole + 150) * 255 / 4096
    localparam int LEVEL_OFFSET = 150;
    localparam int LEVEL_SCALE  = 255;
    localparam int LEVEL_SHIFT  = 12;

    // opcode values
    localparam logic OP_FILTER  = 1'b0;
    localparam logic OP_CONTROL = 1'b1;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_SETPOINT   = 3'd0;
    localparam t_cfg_idx REG_GAIN_NOW   = 3'd1;
    localparam t_cfg_idx REG_GAIN_PREV  = 3'd2;
    localparam t_cfg_idx REG_GAIN_PREV2 = 3'd3;
    localparam t_cfg_idx REG_DUTY_MAX   = 3'd4;

    // register reset values
    typedef logic signed [GAIN_W-1:0] t_gain;
    localparam logic [DUTY_W-1:0] SETPOINT_RST   = 8'd230;
    localparam t_gain             GAIN_NOW_RST   = 32'sd2670559;
    localparam t_gain             GAIN_PREV_RST  = -32'sd5285511;
    localparam t_gain             GAIN_PREV2_RST = 32'sd2621440;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 8'd255;

endpackage

FILE: src/filtered_incremental_pid.sv
// top level of the filtered incremental pid controller
//
// Input channel: i_valid / o_stall carry one item (i_opcode, i_sample). Every item
// moves the exponential average of the samples; an item with the control opcode
// also runs one incremental pid step and yields one result item.
// Output channel: o_valid / i_stall carry (o_duty, o_filtered_level, o_error_now).
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (setpoint,
// three Q16.16 gains, duty limit); indexes past the list are ignored.
// Path: the edge that accepts an item stores the updated average (one
// reciprocal multiply in the feedback loop) and marks a control step pending;
// once the output register is free, the pending step stores the level scaling,
// three gain multiplies and the clamp in the output register.
// Throughput: one item per cycle while o_stall is low; both loops close in logic.
// Stall: when the output register is full and stalled, a pending control step
// holds in the middle register and o_stall rises; filter-only items keep
// flowing as long as no control step is waiting.
// Reset: synchronous, active low; clears the average, the error history, the
// previous duty and the valids, and loads the register reset values.
module filtered_incremental_pid #(
    parameter int AVG_DIVISOR = 1000
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_opcode,
    input  logic [fipid_pkg::SAMPLE_W-1:0]        i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [fipid_pkg::DUTY_W-1:0]          o_duty,
    output logic [fipid_pkg::SAMPLE_W-1:0]        o_filtered_level,
    output logic signed [fipid_pkg::ERR_W-1:0]    o_error_now,
    input  logic                                  i_cfg_we,
    input  logic [fipid_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fipid_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ACC_W  = fipid_pkg::ACC_W;
    localparam int MUL_W  = fipid_pkg::GAIN_W + fipid_pkg::ERR_W;
    localparam int SUM_W  = fipid_pkg::GAIN_W + fipid_pkg::ERR_W + 3;
    localparam int Q_W    = SUM_W - fipid_pkg::GAIN_FRAC;

    // reciprocal of the divisor, exact for every 32-bit magnitude
    localparam int          DIV_SHIFT  = $clog2(AVG_DIVISOR);
    localparam int          QUOT_SHIFT = ACC_W + DIV_SHIFT;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << QUOT_SHIFT) + 64'(AVG_DIVISOR) - 64'd1) / 64'(AVG_DIVISOR);
    localparam int          RECIP_W    = ACC_W + 2;
    localparam int          PROD_W     = ACC_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];

    // configuration registers
    logic [fipid_pkg::DUTY_W-1:0] r_setpoint;
    fipid_pkg::t_gain             r_gain_now;
    fipid_pkg::t_gain             r_gain_prev;
    fipid_pkg::t_gain             r_gain_prev2;
    logic [fipid_pkg::DUTY_W-1:0] r_duty_max;

    // filter state and pending control step
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic             r_p_valid;

    // pid state
    logic signed [fipid_pkg::ERR_W-1:0] r_err_b1;
    logic signed [fipid_pkg::ERR_W-1:0] r_err_b2;
    logic [fipid_pkg::DUTY_W-1:0]       r_last_duty;

    // output register
    logic                               r_out_valid;
    logic [fipid_pkg::DUTY_W-1:0]       r_duty;
    logic [fipid_pkg::SAMPLE_W-1:0]     r_level;
    logic signed [fipid_pkg::ERR_W-1:0] r_err;

    // handshake
    logic in_acc;
    logic out_free;
    logic pid_fire;

    assign out_free = !r_out_valid || !i_stall;
    assign pid_fire = r_p_valid && out_free;
    assign o_stall  = r_p_valid && !out_free;
    assign in_acc   = i_valid && !o_stall;

    // average update: acc moves toward the sample by |diff| / divisor
    logic [ACC_W-1:0]  s_smp_q;
    logic              s_up;
    logic [ACC_W-1:0]  s_mag;
    logic [PROD_W-1:0] s_prod;
    logic [ACC_W-1:0]  s_quot;

    always_comb begin
        s_smp_q = {i_sample, fipid_pkg::FRAC_BITS'(0)};
        s_up    = (s_smp_q >= r_acc);
        s_mag   = s_up ? (s_smp_q - r_acc) : (r_acc - s_smp_q);
        s_prod  = PROD_W'(s_mag) * PROD_W'(RECIP_M);
        s_quot  = ACC_W'(s_prod >> QUOT_SHIFT);
        n_acc   = s_up ? (r_acc + s_quot) : (r_acc - s_quot);
    end

    // level scaling and error
    logic [fipid_pkg::SAMPLE_W-1:0]     s_whole;
    logic [fipid_pkg::SAMPLE_W:0]       s_lvl_base;
    logic [fipid_pkg::SAMPLE_W+8:0]     s_lvl_prod;
    logic [fipid_pkg::LEVEL_W-1:0]      s_level;
    logic signed [fipid_pkg::ERR_W-1:0] s_e0;

    always_comb begin
        s_whole    = r_acc[ACC_W-1 -: fipid_pkg::SAMPLE_W];
        s_lvl_base = (fipid_pkg::SAMPLE_W+1)'(s_whole)
                   + (fipid_pkg::SAMPLE_W+1)'(fipid_pkg::LEVEL_OFFSET);
        s_lvl_prod = (fipid_pkg::SAMPLE_W+9)'(s_lvl_base)
                   * (fipid_pkg::SAMPLE_W+9)'(fipid_pkg::LEVEL_SCALE);
        s_level    = fipid_pkg::LEVEL_W'(s_lvl_prod >> fipid_pkg::LEVEL_SHIFT);
        s_e0       = $signed(fipid_pkg::ERR_W'(r_setpoint) - fipid_pkg::ERR_W'(s_level));
    end

    // incremental pid sum and clamp
    logic signed [MUL_W-1:0]      s_p0;
    logic signed [MUL_W-1:0]      s_p1;
    logic signed [MUL_W-1:0]      s_p2;
    logic signed [SUM_W-1:0]      s_sum;
    logic [Q_W-1:0]               s_q;
    logic [fipid_pkg::DUTY_W-1:0] s_duty;

    always_comb begin
        s_p0  = MUL_W'(r_gain_now) * MUL_W'(s_e0);
        s_p1  = MUL_W'(r_gain_prev) * MUL_W'(r_err_b1);
        s_p2  = MUL_W'(r_gain_prev2) * MUL_W'(r_err_b2);
        s_sum = SUM_W'(s_p0) + SUM_W'(s_p1) + SUM_W'(s_p2)
              + $signed({(SUM_W-fipid_pkg::DUTY_W-fipid_pkg::GAIN_FRAC)'(0),
                         r_last_duty, fipid_pkg::GAIN_FRAC'(0)});
        s_q   = s_sum[SUM_W-1:fipid_pkg::GAIN_FRAC];
        if (s_sum[SUM_W-1]) begin
            s_duty = '0;
        end else if (s_q > Q_W'(r_duty_max)) begin
            s_duty = r_duty_max;
        end else begin
            s_duty = s_q[fipid_pkg::DUTY_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= fipid_pkg::SETPOINT_RST;
            r_gain_now   <= fipid_pkg::GAIN_NOW_RST;
            r_gain_prev  <= fipid_pkg::GAIN_PREV_RST;
            r_gain_prev2 <= fipid_pkg::GAIN_PREV2_RST;
            r_duty_max   <= fipid_pkg::DUTY_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fipid_pkg::REG_SETPOINT:   r_setpoint   <= i_cfg_data[fipid_pkg::DUTY_W-1:0];
                fipid_pkg::REG_GAIN_NOW:   r_gain_now   <= $signed(i_cfg_data);
                fipid_pkg::REG_GAIN_PREV:  r_gain_prev  <= $signed(i_cfg_data);
                fipid_pkg::REG_GAIN_PREV2: r_gain_prev2 <= $signed(i_cfg_data);
                fipid_pkg::REG_DUTY_MAX:   r_duty_max   <= i_cfg_data[fipid_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // filter stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_acc <= n_acc;
            end
            if (in_acc) begin
                r_p_valid <= (i_opcode == fipid_pkg::OP_CONTROL);
            end else if (pid_fire) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    // pid state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_b1    <= '0;
            r_err_b2    <= '0;
            r_last_duty <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pid_fire) begin
                r_err_b2    <= r_err_b1;
                r_err_b1    <= s_e0;
                r_last_duty <= s_duty;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (pid_fire) begin
            r_duty  <= s_duty;
            r_level <= s_whole;
            r_err   <= s_e0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_duty           = r_duty;
    assign o_filtered_level = r_level;
    assign o_error_now      = r_err;

    // the input side only stalls behind a waiting control step
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_p_valid)
        else $error("input stalled without a pending control step");

    // the presented duty is the one kept for the next step
    a_duty_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty == r_last_duty))
        else $error("presented duty differs from kept duty");

    // error history shifts on every control step
    a_err_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pid_fire |=> (r_err_b2 == $past(r_err_b1)) && (r_err_b1 == $past(s_e0)))
        else $error("error history did not shift");

    // without a control step the pid state holds
    a_pid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pid_fire |=> $stable(r_err_b1) && $stable(r_err_b2) && $stable(r_last_duty))
        else $error("pid state changed without a control step");

    // a control step never starts while its result cannot be stored
    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> !($past(r_p_valid) && !r_p_valid && !$past(in_acc)))
        else $error("control step left while the output was blocked");

endmodule
